// File: sv/dpalu_pkg.sv
package dpalu_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned CountBits = 5;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13
  } op_e;

  typedef enum logic [1:0] {
    SHIFT_LSL = 2'd0,
    SHIFT_LSR = 2'd1,
    SHIFT_ASR = 2'd2,
    SHIFT_ROR = 2'd3
  } shift_e;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  typedef struct packed {
    logic                 set_flags;
    logic [CountBits-1:0] shift_count;
    logic [1:0]           shift_kind;
    logic [WordBits-1:0]  second_operand;
    logic [WordBits-1:0]  first_operand;
    logic [3:0]           op;
  } instr_t;

  typedef struct packed {
    logic                bad_opcode;
    logic                overflow_flag;
    logic                carry_flag;
    logic                zero_flag;
    logic                negative_flag;
    logic                write_back;
    logic [WordBits-1:0] result_value;
  } result_t;

  localparam int unsigned InBits = $bits(instr_t);
  localparam int unsigned InBytesBits = ((InBits + 7) / 8) * 8;
  localparam int unsigned OutBits = $bits(result_t);
  localparam int unsigned OutBytesBits = ((OutBits + 7) / 8) * 8;

endpackage

// File: sv/dpalu_core.sv
module dpalu_core
  import dpalu_pkg::*;
(
  input  instr_t  instr_i,
  input  flags_t  flags_i,
  output result_t result_o,
  output flags_t  flags_o
);

  logic [WordBits-1:0]   shifted;
  logic                  shift_carry;
  logic [WordBits:0]     lsl_ext;
  logic [WordBits:0]     lsr_ext;
  logic [WordBits:0]     asr_ext;
  logic [2*WordBits-1:0] ror_ext;
  logic [WordBits:0]     sum_ext;
  logic [WordBits-1:0]   res;
  logic                  alu_carry;
  logic                  wb;
  logic                  bad;

  assign lsl_ext = {1'b0, instr_i.second_operand} << instr_i.shift_count;
  assign lsr_ext = {instr_i.second_operand, 1'b0} >> instr_i.shift_count;
  assign asr_ext = $signed({instr_i.second_operand, 1'b0}) >>> instr_i.shift_count;
  assign ror_ext = {instr_i.second_operand, instr_i.second_operand} >> instr_i.shift_count;

  always_comb begin
    shifted     = instr_i.second_operand;
    shift_carry = flags_i.c;
    if (instr_i.shift_count != '0) begin
      unique case (shift_e'(instr_i.shift_kind))
        SHIFT_LSL: begin
          shifted     = lsl_ext[WordBits-1:0];
          shift_carry = lsl_ext[WordBits];
        end
        SHIFT_LSR: begin
          shifted     = lsr_ext[WordBits:1];
          shift_carry = lsr_ext[0];
        end
        SHIFT_ASR: begin
          shifted     = asr_ext[WordBits:1];
          shift_carry = asr_ext[0];
        end
        SHIFT_ROR: begin
          shifted     = ror_ext[WordBits-1:0];
          shift_carry = ror_ext[WordBits-1];
        end
        default: begin
          shifted     = instr_i.second_operand;
          shift_carry = flags_i.c;
        end
      endcase
    end
  end

  always_comb begin
    sum_ext = '0;
    unique case (op_e'(instr_i.op))
      OP_SUB, OP_CMP: sum_ext = {1'b0, instr_i.first_operand} + {1'b0, ~shifted}
                                + (WordBits+1)'(1);
      OP_RSB:         sum_ext = {1'b0, shifted} + {1'b0, ~instr_i.first_operand}
                                + (WordBits+1)'(1);
      default:        sum_ext = {1'b0, instr_i.first_operand} + {1'b0, shifted};
    endcase
  end

  always_comb begin
    res       = '0;
    alu_carry = shift_carry;
    wb        = 1'b1;
    bad       = 1'b0;
    unique case (op_e'(instr_i.op))
      OP_AND: res = instr_i.first_operand & shifted;
      OP_EOR: res = instr_i.first_operand ^ shifted;
      OP_ORR: res = instr_i.first_operand | shifted;
      OP_MOV: res = shifted;
      OP_TST: begin
        res = instr_i.first_operand & shifted;
        wb  = 1'b0;
      end
      OP_TEQ: begin
        res = instr_i.first_operand ^ shifted;
        wb  = 1'b0;
      end
      OP_SUB, OP_RSB, OP_ADD: begin
        res       = sum_ext[WordBits-1:0];
        alu_carry = sum_ext[WordBits];
      end
      OP_CMP: begin
        res       = sum_ext[WordBits-1:0];
        alu_carry = sum_ext[WordBits];
        wb        = 1'b0;
      end
      default: begin
        res = '0;
        wb  = 1'b0;
        bad = 1'b1;
      end
    endcase
  end

  always_comb begin
    flags_o = flags_i;
    if (instr_i.set_flags && !bad) begin
      flags_o.n = res[WordBits-1];
      flags_o.z = (res == '0);
      flags_o.c = alu_carry;
    end
  end

  assign result_o.result_value  = res;
  assign result_o.write_back    = wb;
  assign result_o.negative_flag = flags_o.n;
  assign result_o.zero_flag     = flags_o.z;
  assign result_o.carry_flag    = flags_o.c;
  assign result_o.overflow_flag = flags_o.v;
  assign result_o.bad_opcode    = bad;

endmodule

// File: sv/arm_data_processing_alu.sv
// ARM data-processing ALU with a barrel shifter on operand two.
// Input beats arrive on the s_axis group; each tdata beat carries, from the
// lowest bit up, op, first_operand, second_operand, shift_kind, shift_count
// and set_flags. Results leave on the m_axis group, one beat per input beat,
// in order.
// An input beat is captured in an input register; the shift, the ALU and
// the flag update sit between that register and the result register, from
// which the result is offered. Throughput is one beat per cycle while the
// receiver keeps m_axis_tready high. Beats with set_flags and a valid opcode
// update the held N, Z and C flags, never V, as they move into the result
// register, so back-to-back beats see the flags of the beat before.
// When the receiver stalls, the result register holds its beat and the input
// register keeps one more; s_axis_tready drops once both are full.
// Reset clears both valid bits and the flags to zero.
module arm_data_processing_alu
  import dpalu_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // Fields from bit 0: op, first_operand, second_operand, shift_kind,
  // shift_count, set_flags, zero pad.
  input  logic [InBytesBits-1:0]  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // Fields from bit 0: result_value, write_back, negative_flag, zero_flag,
  // carry_flag, overflow_flag, bad_opcode, zero pad.
  output logic [OutBytesBits-1:0] m_axis_tdata
);

  logic    in_valid_q;
  instr_t  in_data_q;
  logic    out_valid_q;
  result_t out_data_q;
  flags_t  flags_q;
  flags_t  flags_d;
  result_t result_d;
  logic    advance;
  logic    accept;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  dpalu_core u_core (
    .instr_i  (in_data_q),
    .flags_i  (flags_q),
    .result_o (result_d),
    .flags_o  (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        flags_q     <= flags_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= instr_t'(s_axis_tdata[InBits-1:0]);
    end
    if (advance) begin
      out_data_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutBytesBits-OutBits){1'b0}}, out_data_q};

endmodule
